/* sv/ookpd_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the OOK remote pulse decoder.
// Used by ookpd_front, ookpd_queue, ookpd_back and ook_remote_pulse_decoder.
package ookpd_pkg;

  localparam int DurW      = 16;
  localparam int WordW     = 32;
  localparam int CountW    = 6;
  localparam int ExpW      = 7;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 16;
  localparam int MaxBits   = 32;
  localparam int BitCap    = (MaxBits < WordW) ? MaxBits : WordW;
  localparam int ExpReset  = 24;
  localparam int QueueDepth = 2;

  localparam int InDataW  = ((DurW + 7) / 8) * 8;
  localparam int OutDataW = ((WordW + CountW + 7) / 8) * 8;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SHORT_MIN = 3'd0,
    REG_SHORT_MAX = 3'd1,
    REG_LONG_MIN  = 3'd2,
    REG_LONG_MAX  = 3'd3,
    REG_TERM_MIN  = 3'd4,
    REG_TERM_MAX  = 3'd5,
    REG_EXP_BITS  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic level;
    logic is_short;
    logic is_long;
    logic is_term;
  } pulse_class_t;

endpackage

/* sv/ook_remote_pulse_decoder.sv */
`timescale 1ns / 1ps
// Pulse-width decoder for on-off-keyed remote codes.
// Depends on ookpd_pkg, ookpd_front, ookpd_queue and ookpd_back.
//
// Input stream: one transaction per measured pulse, duration in tdata and
// level in tuser. Each pulse is classed against the short, long and
// terminator windows at acceptance and queued for the bit decoder.
// Output stream: one transaction per terminated frame with the code word,
// its bit count and a length flag.
// Configuration: write-only register port, written by the user only while the
// block is idle; the block itself does not enforce this. Throughput: one pulse
// per cycle while the queue is not full; the decoder state updates once per pulse.
// A terminator pulse goes through the queue, the decoder and the result register.
// Stall: a held result blocks only terminator pulses in the decoder; the
// queue (QUEUE_DEPTH entries) keeps taking pulses until it fills.
// Reset: registers return to their defaults (expected length 24, all
// windows zero), the decoder goes idle and the queue and result slot empty.
module ook_remote_pulse_decoder #(
  parameter int QUEUE_DEPTH = ookpd_pkg::QueueDepth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ookpd_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [ookpd_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [ookpd_pkg::InDataW-1:0]     s_axis_tdata,   // [15:0] duration
  input  logic                              s_axis_tuser,   // [0] level
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [ookpd_pkg::OutDataW-1:0]    m_axis_tdata,   // [31:0] code_word, [37:32] bit_count
  output logic                              m_axis_tuser    // [0] length_ok
);
  import ookpd_pkg::*;

  pulse_class_t       in_class, q_class;
  logic [ExpW-1:0]    exp_bits;
  logic               q_full, q_valid, q_pop;
  logic [WordW-1:0]   res_word;
  logic [CountW-1:0]  res_count;

  ookpd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .level_i    (s_axis_tuser),
    .duration_i (s_axis_tdata[DurW-1:0]),
    .class_o    (in_class),
    .exp_bits_o (exp_bits)
  );

  assign s_axis_tready = !q_full;

  ookpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid),
    .push_data_i (in_class),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_class)
  );

  ookpd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_i       (q_class),
    .item_pop_o   (q_pop),
    .exp_bits_i   (exp_bits),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_word_o   (res_word),
    .res_count_o  (res_count),
    .res_ok_o     (m_axis_tuser)
  );

  assign m_axis_tdata = OutDataW'({res_count, res_word});

endmodule

/* sv/ookpd_front.sv */
`timescale 1ns / 1ps
// Front end: configuration registers and duration window classification.
// Depends on ookpd_pkg.
module ookpd_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ookpd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ookpd_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                            level_i,
  input  logic [ookpd_pkg::DurW-1:0]      duration_i,
  output ookpd_pkg::pulse_class_t         class_o,
  output logic [ookpd_pkg::ExpW-1:0]      exp_bits_o
);
  import ookpd_pkg::*;

  logic [DurW-1:0] short_min_q, short_max_q, long_min_q, long_max_q;
  logic [DurW-1:0] term_min_q, term_max_q;
  logic [ExpW-1:0] exp_bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_min_q <= '0;
      short_max_q <= '0;
      long_min_q  <= '0;
      long_max_q  <= '0;
      term_min_q  <= '0;
      term_max_q  <= '0;
      exp_bits_q  <= ExpW'(ExpReset);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_SHORT_MIN: short_min_q <= cfg_data_i[DurW-1:0];
        REG_SHORT_MAX: short_max_q <= cfg_data_i[DurW-1:0];
        REG_LONG_MIN:  long_min_q  <= cfg_data_i[DurW-1:0];
        REG_LONG_MAX:  long_max_q  <= cfg_data_i[DurW-1:0];
        REG_TERM_MIN:  term_min_q  <= cfg_data_i[DurW-1:0];
        REG_TERM_MAX:  term_max_q  <= cfg_data_i[DurW-1:0];
        REG_EXP_BITS:  exp_bits_q  <= cfg_data_i[ExpW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    class_o.level    = level_i;
    class_o.is_short = (duration_i >= short_min_q) && (duration_i <= short_max_q);
    class_o.is_long  = (duration_i >= long_min_q) && (duration_i <= long_max_q);
    class_o.is_term  = (duration_i >= term_min_q) && (duration_i <= term_max_q);
  end

  assign exp_bits_o = exp_bits_q;

endmodule

/* sv/ookpd_queue.sv */
`timescale 1ns / 1ps
// Short queue of classified pulses between front and back.
// Depends on ookpd_pkg.
module ookpd_queue #(
  parameter int DEPTH = ookpd_pkg::QueueDepth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  ookpd_pkg::pulse_class_t  push_data_i,
  output logic                     full_o,
  input  logic                     pop_i,
  output logic                     valid_o,
  output ookpd_pkg::pulse_class_t  pop_data_o
);
  import ookpd_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  pulse_class_t          entry_q [DEPTH];
  logic [PtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]       count_q;
  logic                  do_push, do_pop;

  assign full_o     = (count_q == CntW'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = entry_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

/* sv/ookpd_back.sv */
`timescale 1ns / 1ps
// Back end: bit decoder state, shift word and registered result slot.
// Depends on ookpd_pkg.
module ookpd_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           item_valid_i,
  input  ookpd_pkg::pulse_class_t        item_i,
  output logic                           item_pop_o,
  input  logic [ookpd_pkg::ExpW-1:0]     exp_bits_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output logic [ookpd_pkg::WordW-1:0]    res_word_o,
  output logic [ookpd_pkg::CountW-1:0]   res_count_o,
  output logic                           res_ok_o
);
  import ookpd_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SHORT = 2'd1,
    PH_LONG  = 2'd2
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [WordW-1:0]    word_q, word_d;
  logic [CountW-1:0]   count_q, count_d;
  logic                ovf_q, ovf_d;
  logic                emit, push_bit, bit_val;
  logic                res_valid_q;
  logic [WordW-1:0]    res_word_q;
  logic [CountW-1:0]   res_count_q;
  logic                res_ok_q;

  always_comb begin
    phase_d  = PH_IDLE;
    emit     = 1'b0;
    push_bit = 1'b0;
    bit_val  = 1'b0;
    if (item_i.level) begin
      priority if (phase_q == PH_IDLE && item_i.is_short) begin
        phase_d = PH_SHORT;
      end else if (phase_q == PH_IDLE && item_i.is_long) begin
        phase_d = PH_LONG;
      end else begin
        phase_d = PH_IDLE;
      end
    end else begin
      priority if (phase_q == PH_LONG && item_i.is_short) begin
        push_bit = 1'b1;
        bit_val  = 1'b1;
      end else if (phase_q == PH_SHORT && item_i.is_long) begin
        push_bit = 1'b1;
      end else if (phase_q == PH_SHORT && item_i.is_term) begin
        emit = 1'b1;
      end else begin
        phase_d = PH_IDLE;
      end
    end
  end

  always_comb begin
    word_d  = '0;
    count_d = '0;
    ovf_d   = 1'b0;
    if (phase_d != PH_IDLE) begin
      word_d  = word_q;
      count_d = count_q;
      ovf_d   = ovf_q;
    end
    if (push_bit) begin
      if (count_q < CountW'(BitCap)) begin
        word_d  = {word_q[WordW-2:0], bit_val};
        count_d = count_q + 1'b1;
        ovf_d   = ovf_q;
      end else begin
        word_d  = word_q;
        count_d = count_q;
        ovf_d   = 1'b1;
      end
    end
  end

  assign item_pop_o = item_valid_i && (!emit || !res_valid_q || res_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      word_q      <= '0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      res_valid_q <= 1'b0;
      res_word_q  <= '0;
      res_count_q <= '0;
      res_ok_q    <= 1'b0;
    end else begin
      if (item_pop_o) begin
        phase_q <= phase_d;
        word_q  <= word_d;
        count_q <= count_d;
        ovf_q   <= ovf_d;
      end
      if (item_pop_o && emit) begin
        res_valid_q <= 1'b1;
        res_word_q  <= word_q;
        res_count_q <= count_q;
        res_ok_q    <= ({1'b0, count_q} == exp_bits_i) && !ovf_q;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_word_o  = res_word_q;
  assign res_count_o = res_count_q;
  assign res_ok_o    = res_ok_q;

endmodule

/* sim/ookpd_checker.sv */
`timescale 1ns / 1ps
// Checker for the OOK remote pulse decoder: watches the register port and both
// streams, decodes accepted pulses itself and compares every emitted frame.
// Depends on ookpd_pkg.
module ookpd_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ookpd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ookpd_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [ookpd_pkg::InDataW-1:0]  s_axis_tdata,   // [15:0] duration
  input  logic                           s_axis_tuser,   // [0] level
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [ookpd_pkg::OutDataW-1:0] m_axis_tdata,   // [31:0] code_word, [37:32] bit_count
  input  logic                           m_axis_tuser,   // [0] length_ok
  output int                             mismatches_o,
  output int                             pending_o
);
  import ookpd_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE       = 2'd0,
    PH_SHORT_HIGH = 2'd1,
    PH_LONG_HIGH  = 2'd2
  } bit_phase_e;

  typedef struct packed {
    logic [WordW-1:0]  word;
    logic [CountW-1:0] count;
    logic              length_ok;
  } frame_t;

  logic [DurW-1:0]   short_lo = '0, short_hi = '0;
  logic [DurW-1:0]   long_lo  = '0, long_hi  = '0;
  logic [DurW-1:0]   term_lo  = '0, term_hi  = '0;
  logic [ExpW-1:0]   want_bits = ExpW'(ExpReset);

  bit_phase_e        dec_phase = PH_IDLE;
  logic [WordW-1:0]  dec_word = '0;
  logic [CountW-1:0] dec_count = '0;
  logic              dec_dropped = 1'b0;

  frame_t            frames_due[$];
  int                mismatches = 0;

  function automatic void drop_frame();
    dec_phase = PH_IDLE;
    dec_word = '0;
    dec_count = '0;
    dec_dropped = 1'b0;
  endfunction

  function automatic void shift_in_bit(input logic b);
    if (dec_count < CountW'(BitCap)) begin
      dec_word = {dec_word[WordW-2:0], b};
      dec_count = dec_count + 1'b1;
    end else begin
      dec_dropped = 1'b1;
    end
    dec_phase = PH_IDLE;
  endfunction

  function automatic void decode_pulse(input logic lvl, input logic [DurW-1:0] dur,
                                       output logic emit, output frame_t fr);
    logic is_short, is_long, is_term;
    is_short = (dur >= short_lo) && (dur <= short_hi);
    is_long  = (dur >= long_lo) && (dur <= long_hi);
    is_term  = (dur >= term_lo) && (dur <= term_hi);
    emit = 1'b0;
    fr = '0;
    if (lvl) begin
      if (dec_phase == PH_IDLE && is_short) begin
        dec_phase = PH_SHORT_HIGH;
      end else if (dec_phase == PH_IDLE && is_long) begin
        dec_phase = PH_LONG_HIGH;
      end else begin
        drop_frame();
      end
    end else if (dec_phase == PH_LONG_HIGH && is_short) begin
      shift_in_bit(1'b1);
    end else if (dec_phase == PH_SHORT_HIGH && is_long) begin
      shift_in_bit(1'b0);
    end else if (dec_phase == PH_SHORT_HIGH && is_term) begin
      emit = 1'b1;
      fr.word = dec_word;
      fr.count = dec_count;
      fr.length_ok = ({1'b0, dec_count} == want_bits) && !dec_dropped;
      drop_frame();
    end else begin
      drop_frame();
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    frame_t due, fr;
    logic   emit;
    if (!rst_ni) begin
      short_lo = '0; short_hi = '0;
      long_lo = '0; long_hi = '0;
      term_lo = '0; term_hi = '0;
      want_bits = ExpW'(ExpReset);
      drop_frame();
      frames_due.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (frames_due.size() == 0) begin
          $display("%0t: unexpected frame: expected none, actual word %h count %0d ok %b",
                   $time, m_axis_tdata[WordW-1:0], m_axis_tdata[WordW+CountW-1:WordW],
                   m_axis_tuser);
          mismatches++;
        end else begin
          due = frames_due.pop_front();
          if (m_axis_tdata[WordW-1:0] !== due.word) begin
            $display("%0t: code_word expected %h actual %h",
                     $time, due.word, m_axis_tdata[WordW-1:0]);
            mismatches++;
          end
          if (m_axis_tdata[WordW+CountW-1:WordW] !== due.count) begin
            $display("%0t: bit_count expected %0d actual %0d",
                     $time, due.count, m_axis_tdata[WordW+CountW-1:WordW]);
            mismatches++;
          end
          if (m_axis_tuser !== due.length_ok) begin
            $display("%0t: length_ok expected %b actual %b",
                     $time, due.length_ok, m_axis_tuser);
            mismatches++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SHORT_MIN: short_lo = cfg_data_i;
          REG_SHORT_MAX: short_hi = cfg_data_i;
          REG_LONG_MIN:  long_lo = cfg_data_i;
          REG_LONG_MAX:  long_hi = cfg_data_i;
          REG_TERM_MIN:  term_lo = cfg_data_i;
          REG_TERM_MAX:  term_hi = cfg_data_i;
          REG_EXP_BITS:  want_bits = cfg_data_i[ExpW-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        decode_pulse(s_axis_tuser, s_axis_tdata[DurW-1:0], emit, fr);
        if (emit) frames_due.push_back(fr);
      end
    end
    mismatches_o <= mismatches;
    pending_o <= frames_due.size();
  end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// Top of the OOK remote pulse decoder bench: drives pulses, register writes and
// output back-pressure; ookpd_checker predicts and compares. Depends on ookpd_pkg.
module testbench;
  import ookpd_pkg::*;

  localparam int          NumPhases   = 11;
  localparam int          PhaseBudget = 60;
  localparam int          PhaseFloor  = 3;
  localparam int          DrainCycles = 8;
  localparam int          StallLimit  = 3000;
  localparam logic [2:0]  RegUnused   = 3'd7;

  localparam logic [DurW:0] DirectedPulses [26] = '{
    {1'b1, 16'd100}, {1'b0, 16'd500}, {1'b1, 16'd500}, {1'b0, 16'd100},
    {1'b1, 16'd200}, {1'b0, 16'd1000},
    {1'b1, 16'd300}, {1'b0, 16'd200}, {1'b1, 16'd200}, {1'b0, 16'd4000},
    {1'b1, 16'd150}, {1'b0, 16'd4000},
    {1'b0, 16'd0}, {1'b1, 16'd65535}, {1'b1, 16'd0},
    {1'b1, 16'd150}, {1'b1, 16'd150}, {1'b0, 16'd2000},
    {1'b1, 16'd400}, {1'b0, 16'd2000},
    {1'b1, 16'd150}, {1'b0, 16'd4001}, {1'b1, 16'd99}, {1'b1, 16'd150}, {1'b0, 16'd999},
    {1'b0, 16'd65535}
  };

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]    cfg_idx_i = '0;
  logic [CfgDataW-1:0]   cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [InDataW-1:0]    s_axis_tdata = '0;   // [15:0] duration
  logic                  s_axis_tuser = 1'b0; // [0] level
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OutDataW-1:0]   m_axis_tdata;        // [31:0] code_word, [37:32] bit_count
  logic                  m_axis_tuser;        // [0] length_ok

  int                    mismatches;
  int                    pending;
  int unsigned           send_idle_pct = 0;
  int unsigned           recv_stall_pct = 0;
  int unsigned           pulses_sent = 0;
  int unsigned           frames_seen = 0;
  int unsigned           quiet_cycles = 0;

  int unsigned           sh_lo, sh_hi, lg_lo, lg_hi, tm_lo, tm_hi, exp_len;
  logic                  can_emit;

  ook_remote_pulse_decoder dut (.*);

  ookpd_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .mismatches_o(mismatches), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) frames_seen++;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic load_windows(input int unsigned s_lo, s_hi, l_lo, l_hi, t_lo, t_hi,
                              input logic [CfgDataW-1:0] exp_data);
    write_reg(REG_SHORT_MIN, CfgDataW'(s_lo));
    write_reg(REG_SHORT_MAX, CfgDataW'(s_hi));
    write_reg(REG_LONG_MIN, CfgDataW'(l_lo));
    write_reg(REG_LONG_MAX, CfgDataW'(l_hi));
    write_reg(REG_TERM_MIN, CfgDataW'(t_lo));
    write_reg(REG_TERM_MAX, CfgDataW'(t_hi));
    write_reg(REG_EXP_BITS, exp_data);
    write_reg(RegUnused, 16'hFFFF);
    cfg_we_i <= 1'b0;
    sh_lo = s_lo; sh_hi = s_hi;
    lg_lo = l_lo; lg_hi = l_hi;
    tm_lo = t_lo; tm_hi = t_hi;
    exp_len = 32'(exp_data[ExpW-1:0]);
    can_emit = (sh_lo <= sh_hi) && (tm_lo <= tm_hi) && !(lg_lo <= tm_lo && tm_hi <= lg_hi);
  endtask

  task automatic load_random_windows(input logic [CfgDataW-1:0] exp_data);
    int unsigned s_lo, s_hi, l_lo, l_hi, t_lo, t_hi;
    s_lo = $urandom_range(3000);
    s_hi = s_lo + $urandom_range(600);
    l_lo = s_lo + $urandom_range(2000);
    l_hi = l_lo + $urandom_range(3000);
    t_lo = $urandom_range(40000, l_lo);
    t_hi = t_lo + $urandom_range(25000);
    load_windows(s_lo, s_hi, l_lo, l_hi, t_lo, t_hi, exp_data);
  endtask

  function automatic logic [DurW-1:0] pick_in(input int unsigned lo, hi);
    if ($urandom_range(99) < 3) return DurW'($urandom_range(65535));
    if (lo <= hi) return DurW'($urandom_range(hi, lo));
    return DurW'($urandom_range(65535));
  endfunction

  task automatic send_pulse(input logic lvl, input logic [DurW-1:0] dur);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= lvl;
    s_axis_tdata <= InDataW'(dur);
    do @(posedge clk_i); while (!s_axis_tready);
    pulses_sent++;
  endtask

  task automatic send_frame();
    int unsigned r, nbits;
    r = $urandom_range(99);
    if (r < 45) begin
      nbits = (exp_len > 36) ? $urandom_range(36, 30) : exp_len;
    end else if (r < 75) begin
      nbits = $urandom_range(6);
    end else begin
      nbits = $urandom_range(36);
    end
    repeat (nbits) begin
      if ($urandom_range(1)) begin
        send_pulse(1'b1, pick_in(lg_lo, lg_hi));
        send_pulse(1'b0, pick_in(sh_lo, sh_hi));
      end else begin
        send_pulse(1'b1, pick_in(sh_lo, sh_hi));
        send_pulse(1'b0, pick_in(lg_lo, lg_hi));
      end
    end
    send_pulse(1'b1, pick_in(sh_lo, sh_hi));
    send_pulse(1'b0, pick_in(tm_lo, tm_hi));
  endtask

  task automatic send_noise();
    repeat ($urandom_range(6, 1)) begin
      send_pulse(1'($urandom_range(1)), DurW'($urandom_range(65535)));
    end
    send_pulse(1'b0, DurW'($urandom_range(65535)));
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    int unsigned s0, r0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int p = 0; p < NumPhases; p++) begin
      if (p < 4) begin
        send_idle_pct = 30;
        recv_stall_pct = 83;
      end else if (p < 8) begin
        send_idle_pct = 83;
        recv_stall_pct = 30;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      case (p)
        0:  load_windows(100, 200, 300, 500, 1000, 4000, 16'd2);
        1:  load_windows(100, 200, 300, 500, 1000, 4000, 16'd4);
        2:  load_windows(0, 0, 1, 1, 2, 65535, 16'd1);
        3:  load_random_windows(16'd32);
        4:  load_windows(50, 400, 300, 800, 700, 3000, 16'd3);
        5:  load_windows(500, 100, 300, 800, 900, 600, 16'd0);
        6:  load_windows(0, 65535, 0, 65535, 0, 65535, 16'd127);
        7:  load_random_windows(16'($urandom_range(10, 1)));
        8:  load_windows(10, 20, 30, 60, 100, 65535, 16'd33);
        9:  load_windows(65533, 65533, 65534, 65534, 65535, 65535, 16'hFF40);
        default: load_random_windows(16'($urandom_range(8, 1)));
      endcase
      if (p == 0) begin
        foreach (DirectedPulses[i]) send_pulse(DirectedPulses[i][DurW], DirectedPulses[i][DurW-1:0]);
      end else begin
        s0 = pulses_sent;
        r0 = frames_seen;
        while (pulses_sent - s0 < 4 * PhaseBudget &&
               (pulses_sent - s0 < PhaseBudget ||
                (can_emit && frames_seen - r0 < PhaseFloor))) begin
          if ($urandom_range(99) < 80) send_frame();
          else send_noise();
        end
      end
      s_axis_tvalid <= 1'b0;
      wait_drained();
    end
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
